@@ sv/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg : shared types and constants for the sliding window median
// Window depth, counter widths and the word carried between sorting cells.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int DATA_W     = 32;
   localparam int IDX_W      = $clog2(WINDOW_MAX);
   localparam int CNT_W      = 7;

   // one slot of the sorted row
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
   } swm_slot_type;

   // per-word control broadcast along the row
   typedef struct packed {
      logic                     shift;
      logic                     clear;
      logic                     evict;
      logic signed [DATA_W-1:0] sample;
      logic signed [DATA_W-1:0] oldest;
   } swm_ctrl_type;

endpackage

@@ sv/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell : one slot of the sorted sample row
// Removes the oldest sample and inserts the new one using only its
// neighbours, so the whole row re-sorts in the cycle the new sample arrives.
// ----------------------------------------------------------------------------
module swm_cell
   import swm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  swm_ctrl_type ctrl,
   input  swm_slot_type right_slot,  // current slot of cell j+1
   input  swm_slot_type left_rem,    // cell j-1 after removal
   input  logic         left_big,    // left_rem sorts after the sample
   output swm_slot_type slot,
   output swm_slot_type rem,
   output logic         rem_big
);

   swm_slot_type slot_ff;
   swm_slot_type slot_in;
   logic         at_or_past;

   // slots at or right of the oldest sample close the gap from the right;
   // the oldest of equal values is the leftmost of them
   assign at_or_past = ctrl.evict && (!slot_ff.valid || (slot_ff.value >= ctrl.oldest));
   assign rem        = at_or_past ? right_slot : slot_ff;
   // equal values keep arrival order: the new word goes after them
   assign rem_big    = !rem.valid || (rem.value > ctrl.sample);

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.clear) begin
         slot_in.valid = 1'b0;
      end else if (ctrl.shift) begin
         if (left_big) begin
            slot_in = left_rem;
         end else if (rem_big) begin
            slot_in.valid = 1'b1;
            slot_in.value = ctrl.sample;
         end else begin
            slot_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.value <= slot_in.value;
   end

   assign slot = slot_ff;

endmodule

@@ sv/swm_hist.sv @@
// ----------------------------------------------------------------------------
// swm_hist : arrival history of the samples
// Circular buffer that presents the sample due to leave the window at the
// next accepted word.
// ----------------------------------------------------------------------------
module swm_hist
   import swm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic signed [DATA_W-1:0] sample,
   input  logic [CNT_W-1:0]         window,
   output logic signed [DATA_W-1:0] oldest
);

   logic signed [DATA_W-1:0] hist_mem [WINDOW_MAX];
   logic [IDX_W-1:0]         wr_ptr_ff;
   logic [IDX_W-1:0]         wr_ptr_in;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] rd_data_ff;
   logic signed [DATA_W-1:0] last_ff;
   logic                     bypass_ff;
   logic [CNT_W-1:0]         back;

   // next to leave: the word written window-1 words before this one
   assign back      = window - CNT_W'(1);
   assign rd_addr   = wr_ptr_ff - back[IDX_W-1:0];
   assign wr_ptr_in = wr_ptr_ff + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
      end else if (push) begin
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         hist_mem[wr_ptr_ff] <= sample;
         rd_data_ff          <= hist_mem[rd_addr];
         last_ff             <= sample;
         bypass_ff           <= (window == CNT_W'(1));
      end
   end

   // a window of one evicts the word just written
   assign oldest = bypass_ff ? last_ff : rd_data_ff;

endmodule

@@ sv/sliding_window_median.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median : lower median over the most recent samples
// Sorted row of cells with an arrival history to locate the oldest sample.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_sample carry one signed sample per word. A word
//   is taken on a clock edge with req_valid high and req_stall low.
//   rsp_valid/rsp_stall/rsp_median return the lower median of the last
//   window_size samples, one word for every sample once the window is full.
//   csr_wr_en/csr_wr_data set window_size (0 acts as 1, above 64 as 64);
//   every write empties the window, so it refills before the next result.
// Timing:
//   One sample per cycle while req_stall is low. The row of cells re-sorts
//   in the cycle a sample is taken; the median tap is then registered into
//   the output register once that register is free.
// Reset:
//   Synchronous. Window size returns to 1 and the window is emptied.
// Back-pressure:
//   The output register holds its word while rsp_stall is high. A finished
//   result waits in the row; a new sample is refused only while that result
//   cannot yet move into a full, stalled output register.
// ----------------------------------------------------------------------------
module sliding_window_median
   import swm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_median,
   input  logic                     csr_wr_en,
   input  logic [CNT_W-1:0]         csr_wr_data
);

   logic [CNT_W-1:0]         window_ff;
   logic [CNT_W-1:0]         window_eff;
   logic [CNT_W-1:0]         fill_ff;
   logic [CNT_W-1:0]         fill_in;
   logic                     pending_ff;
   logic                     pending_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_median_ff;
   logic                     out_free;
   logic                     accept;
   logic                     full;
   logic                     done;
   logic [CNT_W-1:0]         mid_full;
   logic [IDX_W-1:0]         mid;
   logic signed [DATA_W-1:0] oldest;
   swm_ctrl_type             ctrl;

   swm_slot_type slot   [WINDOW_MAX];
   swm_slot_type rem    [WINDOW_MAX];
   logic         rem_big[WINDOW_MAX];

   always_comb begin
      if (window_ff == '0) begin
         window_eff = CNT_W'(1);
      end else if (window_ff > CNT_W'(WINDOW_MAX)) begin
         window_eff = CNT_W'(WINDOW_MAX);
      end else begin
         window_eff = window_ff;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pending_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign full      = (fill_ff == window_eff);
   assign done      = full || ((fill_ff + CNT_W'(1)) == window_eff);

   assign ctrl.shift  = accept;
   assign ctrl.clear  = csr_wr_en;
   assign ctrl.evict  = full;
   assign ctrl.sample = req_sample;
   assign ctrl.oldest = oldest;

   swm_hist u_hist (
      .clock  (clock),
      .reset  (reset),
      .push   (accept),
      .sample (req_sample),
      .window (window_eff),
      .oldest (oldest)
   );

   for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
      swm_slot_type right_slot;
      swm_slot_type left_rem;
      logic         left_big;

      if (j == WINDOW_MAX - 1) begin : g_last
         assign right_slot = '0;
      end else begin : g_mid
         assign right_slot = slot[j+1];
      end

      if (j == 0) begin : g_first
         assign left_rem = '0;
         assign left_big = 1'b0;
      end else begin : g_rest
         assign left_rem = rem[j-1];
         assign left_big = rem_big[j-1];
      end

      swm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .right_slot (right_slot),
         .left_rem   (left_rem),
         .left_big   (left_big),
         .slot       (slot[j]),
         .rem        (rem[j]),
         .rem_big    (rem_big[j])
      );
   end

   assign mid_full = (window_eff - CNT_W'(1)) >> 1;
   assign mid      = mid_full[IDX_W-1:0];

   always_comb begin
      fill_in      = fill_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = pending_ff;
         pending_in   = 1'b0;
      end
      if (csr_wr_en) begin
         fill_in = '0;
      end else if (accept) begin
         if (!full) begin
            fill_in = fill_ff + CNT_W'(1);
         end
         pending_in = done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= CNT_W'(1);
         fill_ff      <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
         fill_ff      <= fill_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // the row still holds the finished window while the tap is taken
   always_ff @(posedge clock) begin
      if (out_free && pending_ff) begin
         rsp_median_ff <= slot[mid].value;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule
